/* hw/rtl/rat_pkg.sv */
// ----------------------------------------------------------------------------
// Retransmit/ack tracker package
// Shared constants, command and status codes, and the types that travel
// between the tracker's modules.
// ----------------------------------------------------------------------------
package rat_pkg;

   // Table size, and the bound below which a data type may be polled.
   localparam int MAX_SLOTS  = 16;
   localparam int TYPE_LIMIT = 4;

   // Slot index and slot count widths follow from the table size.
   localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

   // Configuration port address width: four registers, one word each.
   localparam int CSR_AW = 4;

   // Register indexes.
   localparam logic [1:0] REG_ACTIVE_TYPE   = 2'd0;
   localparam logic [1:0] REG_ENTRY_COUNT   = 2'd1;
   localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;
   localparam logic [1:0] REG_RETRY_LIMIT   = 2'd3;

   // Register reset values.
   localparam logic [7:0] TIMEOUT_RESET = 8'd4;
   localparam logic [1:0] RETRY_RESET   = 2'd3;

   // Command codes.
   localparam logic [1:0] CMD_TRANSMIT = 2'd0;
   localparam logic [1:0] CMD_ACK      = 2'd1;
   localparam logic [1:0] CMD_POLL     = 2'd2;

   // Status codes.
   localparam logic [2:0] STS_OK         = 3'd0;
   localparam logic [2:0] STS_WRONG_TYPE = 3'd1;
   localparam logic [2:0] STS_RANGE      = 3'd2;
   localparam logic [2:0] STS_TOO_SOON   = 3'd3;
   localparam logic [2:0] STS_SEND_FAIL  = 3'd4;
   localparam logic [2:0] STS_ALL_ACKED  = 3'd5;
   localparam logic [2:0] STS_PENDING    = 3'd6;
   localparam logic [2:0] STS_NOT_CONFIG = 3'd7;

   // One request.
   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  data_kind;
      logic [7:0]  slot_id;
      logic [31:0] now_time;
      logic [7:0]  send_result;
   } req_type;

   // One response.
   typedef struct packed {
      logic [2:0] status;
      logic       send_issued;
      logic [7:0] send_error_code;
      logic       retransmit;
      logic       give_up;
      logic [3:0] event_slot;
   } rsp_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Commands from the sequencer to the slot table.
   typedef struct packed {
      logic              clear;
      logic [SLOT_W-1:0] addr;
      logic              record_send;
      logic              set_acked;
      logic              bump_retry;
   } tbl_ctl_type;

   // Status of the addressed slot and of the whole table.
   typedef struct packed {
      logic acked;
      logic sent;
      logic retry_left;
      logic too_soon;
      logic expired;
      logic pending;
   } tbl_sts_type;

endpackage

/* hw/rtl/retransmit_ack_tracker_top.sv */
// ----------------------------------------------------------------------------
// Retransmit/ack tracker
// Acknowledgement and retransmission bookkeeping for the packet slots of
// one configured data type.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on req_valid/req_data and are taken at an edge where
// req_stall is low. Each request gives exactly one response on
// rsp_valid/rsp_data, held until an edge where rsp_stall is low.
// Transmit, ack and unknown commands pass through the EXEC and DONE states
// before rsp_valid rises. A poll that finds a slot pending walks the slots
// in use one per cycle through the shared age subtractor in the SCAN state,
// stopping at the first timed-out slot or after the last slot in use (at
// most MAX_SLOTS). One request is worked on at a time; req_stall is high
// from acceptance until the response is moved to the output register.
// The output register lets the next request be accepted while a response
// still waits; a stalled receiver holds the following response in the
// sequencer until the output register frees up.
// Reset loads the register defaults and clears every slot. A configuration
// write over the csr_ port also clears every slot; the user must do it only
// while the block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module retransmit_ack_tracker_top
   import rat_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // Request channel.
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   // Response channel.
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   // Configuration port.
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [3:0] active_type_ff;
   logic [4:0] entry_count_ff;
   logic [7:0] timeout_ticks_ff;
   logic [1:0] retry_limit_ff;

   state_type         state_ff, state_in;
   req_type           req_ff;
   rsp_type           res_ff, res_in;
   logic [SLOT_W-1:0] scan_idx_ff, scan_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff;

   logic              csr_write;
   logic              req_accept;
   logic              rsp_load;
   logic [CNT_W-1:0]  slot_count;
   logic              slot_oor;
   logic              not_config;
   tbl_ctl_type       ctl;
   tbl_sts_type       sts;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_type_ff   <= 4'd0;
         entry_count_ff   <= 5'd0;
         timeout_ticks_ff <= TIMEOUT_RESET;
         retry_limit_ff   <= RETRY_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_ACTIVE_TYPE:   active_type_ff   <= csr_pwdata[3:0];
            REG_ENTRY_COUNT:   entry_count_ff   <= csr_pwdata[4:0];
            REG_TIMEOUT_TICKS: timeout_ticks_ff <= csr_pwdata[7:0];
            REG_RETRY_LIMIT:   retry_limit_ff   <= csr_pwdata[1:0];
            default:           ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_ACTIVE_TYPE:   csr_prdata = 32'(active_type_ff);
         REG_ENTRY_COUNT:   csr_prdata = 32'(entry_count_ff);
         REG_TIMEOUT_TICKS: csr_prdata = 32'(timeout_ticks_ff);
         REG_RETRY_LIMIT:   csr_prdata = 32'(retry_limit_ff);
         default:           csr_prdata = 32'd0;
      endcase
   end

   // Effective slot count and the checks built on it.
   assign slot_count = (32'(entry_count_ff) > 32'(MAX_SLOTS)) ?
                       CNT_W'(MAX_SLOTS) : CNT_W'(entry_count_ff);
   assign slot_oor   = 32'(req_ff.slot_id) >= 32'(slot_count);
   assign not_config = (active_type_ff == 4'd0) ||
                       (32'(active_type_ff) >= 32'(TYPE_LIMIT)) ||
                       (slot_count == '0);

   // Handshakes.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   rat_slot_table u_table (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .now_time      (req_ff.now_time),
      .timeout_ticks (timeout_ticks_ff),
      .retry_limit   (retry_limit_ff),
      .slot_count    (slot_count),
      .sts           (sts)
   );

   // Sequencer: next state, table commands and the response being built.
   always_comb begin
      state_in        = state_ff;
      res_in          = res_ff;
      scan_idx_in     = scan_idx_ff;
      rsp_load        = 1'b0;
      ctl.clear       = csr_write;
      ctl.addr        = (state_ff == ST_SCAN) ? scan_idx_ff : req_ff.slot_id[SLOT_W-1:0];
      ctl.record_send = 1'b0;
      ctl.set_acked   = 1'b0;
      ctl.bump_retry  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            res_in   = '0;
            state_in = ST_DONE;
            unique case (req_ff.command) inside
               CMD_TRANSMIT, CMD_ACK: begin
                  if (req_ff.data_kind != 8'(active_type_ff)) begin
                     res_in.status = STS_WRONG_TYPE;
                  end else if (slot_oor) begin
                     res_in.status = STS_RANGE;
                  end else if (req_ff.command == CMD_ACK) begin
                     ctl.set_acked = 1'b1;
                  end else if (sts.too_soon) begin
                     res_in.status = STS_TOO_SOON;
                  end else if (!sts.acked) begin
                     res_in.send_issued = 1'b1;
                     if (req_ff.send_result == 8'd0) begin
                        ctl.record_send = 1'b1;
                     end else begin
                        res_in.status          = STS_SEND_FAIL;
                        res_in.send_error_code = req_ff.send_result;
                     end
                  end
               end
               CMD_POLL: begin
                  if (not_config) begin
                     res_in.status = STS_NOT_CONFIG;
                  end else if (!sts.pending) begin
                     res_in.status = STS_ALL_ACKED;
                  end else begin
                     res_in.status = STS_PENDING;
                     scan_idx_in   = '0;
                     state_in      = ST_SCAN;
                  end
               end
               default: ;
            endcase
         end

         // One slot per cycle; stop at the first timed-out one.
         ST_SCAN: begin
            if (sts.sent && !sts.acked && sts.expired) begin
               if (sts.retry_left) begin
                  res_in.retransmit = 1'b1;
                  ctl.bump_retry    = 1'b1;
               end else begin
                  res_in.give_up = 1'b1;
               end
               res_in.event_slot = 4'(scan_idx_ff);
               state_in          = ST_DONE;
            end else if (32'(scan_idx_ff) + 32'd1 >= 32'(slot_count)) begin
               state_in = ST_DONE;
            end else begin
               scan_idx_in = scan_idx_ff + SLOT_W'(1);
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Output register valid.
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_data;
      end
      res_ff      <= res_in;
      scan_idx_ff <= scan_idx_in;
      if (rsp_load) begin
         rsp_data_ff <= res_ff;
      end
   end

endmodule

/* hw/rtl/rat_slot_table.sv */
// ----------------------------------------------------------------------------
// Retransmit/ack tracker slot table
// Per-slot acknowledged and sent flags, last send times and retry counts,
// with the single age subtractor and window compare used by transmit and poll.
// ----------------------------------------------------------------------------
module rat_slot_table
   import rat_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  tbl_ctl_type       ctl,
   input  logic [31:0]       now_time,
   input  logic [7:0]        timeout_ticks,
   input  logic [1:0]        retry_limit,
   input  logic [CNT_W-1:0]  slot_count,
   output tbl_sts_type       sts
);

   logic [MAX_SLOTS-1:0] acked_ff;
   logic [MAX_SLOTS-1:0] sent_ff;
   logic [1:0]           retry_ff [MAX_SLOTS];
   logic [31:0]          time_mem [MAX_SLOTS];

   logic [31:0] time_rd;
   logic [31:0] age;
   logic        pending;

   // A slot that was never sent reads a send time of zero.
   assign time_rd = sent_ff[ctl.addr] ? time_mem[ctl.addr] : 32'd0;

   // Shared age unit: one subtract and the window compares.
   assign age = now_time - time_rd;

   // Any slot in use that is still waiting for its acknowledgement.
   always_comb begin
      pending = 1'b0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         if (!acked_ff[i] && (32'(i) < 32'(slot_count))) begin
            pending = 1'b1;
         end
      end
   end

   always_comb begin
      sts.acked      = acked_ff[ctl.addr];
      sts.sent       = sent_ff[ctl.addr];
      sts.retry_left = retry_ff[ctl.addr] < retry_limit;
      sts.too_soon   = age < 32'(timeout_ticks);
      sts.expired    = age > 32'(timeout_ticks);
      sts.pending    = pending;
   end

   // Send times; the sent flag marks which entries hold a real time.
   always_ff @(posedge clock) begin
      if (ctl.record_send) begin
         time_mem[ctl.addr] <= now_time;
      end
   end

   // Flags and retry counts, cleared by reset and by any configuration write.
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         acked_ff <= '0;
         sent_ff  <= '0;
         for (int i = 0; i < MAX_SLOTS; i++) begin
            retry_ff[i] <= 2'd0;
         end
      end else begin
         if (ctl.set_acked) begin
            acked_ff[ctl.addr] <= 1'b1;
         end
         if (ctl.record_send) begin
            sent_ff[ctl.addr] <= 1'b1;
         end
         if (ctl.bump_retry) begin
            retry_ff[ctl.addr] <= retry_ff[ctl.addr] + 2'd1;
         end
      end
   end

endmodule
